### hw/rtl/gamepad_poll_deadzone_conditioner_macros.svh
// ----------------------------------------------------------------------------
// Gamepad poll conditioner assertion macros
// Shared assertion forms for the conditioner's checker.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_POLL_DEADZONE_CONDITIONER_MACROS_SVH
`define GAMEPAD_POLL_DEADZONE_CONDITIONER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GPDC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GPDC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gpdc_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad poll conditioner package
// Payload types, register indexes, result kinds and arithmetic constants.
// ----------------------------------------------------------------------------
package gpdc_pkg;

  localparam int PAD_COUNT_DEF = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DZ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DZ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY      = 2'd3;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [14:0] LEFT_DZ_RST    = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST   = 15'd8689;
  localparam logic [7:0]  TRIG_LEVEL_RST = 8'd30;
  localparam logic [15:0] RETRY_RST      = 16'd5000;

  // Poll status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DEVICE = 2'd1;

  // Result kinds
  localparam logic [1:0] EVT_CONNECT    = 2'd0;
  localparam logic [1:0] EVT_DISCONNECT = 2'd1;
  localparam logic [1:0] EVT_STATE      = 2'd2;

  // Full scale of the raw stick and trigger units
  localparam logic [14:0] STICK_FULL = 15'h7FFF;
  localparam logic [7:0]  TRIG_FULL  = 8'hFF;

  // Output limits
  localparam logic [15:0] Q15_POS_MAX = 16'h7FFF;
  localparam logic [15:0] Q15_NEG_MAG = 16'h8000;
  localparam logic [15:0] Q16_MAX     = 16'hFFFF;

  // Shared divider: quotient width and bits retired per cycle
  localparam int QUO_W     = 16;
  localparam int STEP_BITS = 4;
  localparam int DIV_STEPS = QUO_W / STEP_BITS;

  typedef struct packed {
    logic [1:0]         pad_index;
    logic [63:0]        now_tick;
    logic [1:0]         poll_status;
    logic [31:0]        packet_number;
    logic [15:0]        button_bits;
    logic signed [15:0] left_x_raw;
    logic signed [15:0] left_y_raw;
    logic signed [15:0] right_x_raw;
    logic signed [15:0] right_y_raw;
    logic [7:0]         left_trig_raw;
    logic [7:0]         right_trig_raw;
  } poll_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [1:0]         pad_out;
    logic [15:0]        buttons_out;
    logic signed [15:0] left_x_out;
    logic signed [15:0] left_y_out;
    logic signed [15:0] right_x_out;
    logic signed [15:0] right_y_out;
    logic [15:0]        left_trig_out;
    logic [15:0]        right_trig_out;
    logic               last_of_run;
  } result_item_t;

endpackage

### hw/rtl/gamepad_poll_deadzone_conditioner.sv
// Flow: a poll is checked, may send a connect event, then runs setup and divide
// steps per lane before its state result loads; a disconnect event loads after the check.
// Polls are taken one at a time; the shared divider retires 4 quotient bits a cycle
// over six axes; ignored polls return to idle after the check.
// Reset: synchronous rst restores register defaults, clears all pad state and
// drops the result register.
// ----------------------------------------------------------------------------
// Gamepad poll dead zone conditioner
// Gates controller polls per pad, emits connect and disconnect events, and
// rescales stick axes and triggers with one shared restoring divider.
// ----------------------------------------------------------------------------
module gamepad_poll_deadzone_conditioner
  import gpdc_pkg::*;
#(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  poll_valid,
  output logic                  poll_stall,
  input  poll_item_t            poll_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_item_t          result_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PAD_W    = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int STEP_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int LANE_CNT = 6;
  localparam int LANE_W   = 3;

  localparam logic [LANE_W-1:0] LANE_LX = 3'd0;
  localparam logic [LANE_W-1:0] LANE_LY = 3'd1;
  localparam logic [LANE_W-1:0] LANE_RX = 3'd2;
  localparam logic [LANE_W-1:0] LANE_RY = 3'd3;
  localparam logic [LANE_W-1:0] LANE_LT = 3'd4;
  localparam logic [LANE_W-1:0] LANE_RT = 3'd5;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CONN  = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_SEND  = 3'd5;
  localparam logic [2:0] S_DISC  = 3'd6;

  // Configuration
  logic [14:0] left_dz;
  logic [14:0] right_dz;
  logic [7:0]  trig_level;
  logic [15:0] retry_ticks;

  // Per-pad state
  logic [63:0]          retry_due   [PAD_COUNT];
  logic [31:0]          seen_packet [PAD_COUNT];
  logic [PAD_COUNT-1:0] is_linked;

  // Sequencer and divider
  logic [2:0]        state;
  poll_item_t        item;
  logic [LANE_W-1:0] lane;
  logic [STEP_W-1:0] step;
  logic [QUO_W-1:0]  rem;
  logic [QUO_W-1:0]  low;
  logic [QUO_W-1:0]  quo;
  logic [QUO_W-1:0]  dvs;
  logic              lane_zero;
  logic              lane_sat;
  logic              lane_neg;
  logic              lane_trig;
  logic [15:0]       res [LANE_CNT];

  function automatic logic [15:0] finish(input logic [15:0] q, input logic zero,
                                         input logic sat, input logic neg,
                                         input logic trig);
    logic [15:0] v;
    if (zero) begin
      v = '0;
    end else if (trig) begin
      v = sat ? Q16_MAX : q;
    end else if (neg) begin
      v = (sat || q > Q15_NEG_MAG) ? Q15_NEG_MAG : 16'(16'd0 - q);
    end else begin
      v = (sat || q > Q15_POS_MAX) ? Q15_POS_MAX : q;
    end
    return v;
  endfunction

  // Pad lookup
  logic [PAD_W-1:0] pad_sel;
  logic             pad_ok;
  logic             due;
  logic             linked;
  logic [63:0]      retry_at;

  assign pad_sel  = PAD_W'(item.pad_index);
  assign pad_ok   = int'(item.pad_index) < PAD_COUNT;
  assign due      = pad_ok && (retry_due[pad_sel] == '0 ||
                               item.now_tick >= retry_due[pad_sel]);
  assign linked   = is_linked[pad_sel];
  assign retry_at = 64'(item.now_tick + {48'd0, retry_ticks});

  // Lane operand setup
  logic [15:0] raw_sel;
  logic [14:0] dz_sel;
  logic        s_neg;
  logic [15:0] s_mag;
  logic [7:0]  t_val;
  logic [7:0]  t_diff;
  logic [15:0] op_h;
  logic [15:0] op_d;
  logic [15:0] op_den;
  logic        op_zero;
  logic        op_trig;

  always_comb begin
    case (lane)
      LANE_LX: raw_sel = item.left_x_raw;
      LANE_LY: raw_sel = item.left_y_raw;
      LANE_RX: raw_sel = item.right_x_raw;
      LANE_RY: raw_sel = item.right_y_raw;
      default: raw_sel = '0;
    endcase
    dz_sel  = (lane == LANE_LX || lane == LANE_LY) ? left_dz : right_dz;
    s_neg   = raw_sel[15];
    s_mag   = s_neg ? 16'(~raw_sel + 16'd1) : raw_sel;
    t_val   = (lane == LANE_RT) ? item.right_trig_raw : item.left_trig_raw;
    t_diff  = 8'(t_val - trig_level);
    op_trig = (lane == LANE_LT || lane == LANE_RT);
    if (op_trig) begin
      op_zero = (t_val < trig_level) || (trig_level == TRIG_FULL);
      op_h    = {7'd0, t_diff, 1'b0};
      op_den  = {8'd0, 8'(TRIG_FULL - trig_level)};
      op_d    = {7'd0, 8'(TRIG_FULL - trig_level), 1'b0};
    end else begin
      op_zero = s_mag <= {1'b0, dz_sel};
      op_h    = 16'(s_mag - {1'b0, dz_sel});
      op_den  = {1'b0, 15'(STICK_FULL - dz_sel)};
      op_d    = {15'(STICK_FULL - dz_sel), 1'b0};
    end
  end

  // Divider: retire STEP_BITS quotient bits per cycle
  logic [QUO_W-1:0] rem_next;
  logic [QUO_W-1:0] low_next;
  logic [QUO_W-1:0] quo_next;

  always_comb begin
    logic [QUO_W:0] trial;
    rem_next = rem;
    low_next = low;
    quo_next = quo;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial    = {rem_next, low_next[QUO_W-1]};
      low_next = {low_next[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next = QUO_W'(trial - {1'b0, dvs});
        quo_next = {quo_next[QUO_W-2:0], 1'b1};
      end else begin
        rem_next = trial[QUO_W-1:0];
        quo_next = {quo_next[QUO_W-2:0], 1'b0};
      end
    end
  end

  logic out_free;
  logic res_load;
  assign out_free   = !result_valid || !result_stall;
  assign res_load   = out_free && (state == S_CONN || state == S_DISC || state == S_SEND);
  assign poll_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz      <= LEFT_DZ_RST;
      right_dz     <= RIGHT_DZ_RST;
      trig_level   <= TRIG_LEVEL_RST;
      retry_ticks  <= RETRY_RST;
      state        <= S_IDLE;
      result_valid <= 1'b0;
      is_linked    <= '0;
      lane         <= '0;
      step         <= '0;
      for (int p = 0; p < PAD_COUNT; p++) begin
        retry_due[p]   <= '0;
        seen_packet[p] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_LEFT_DZ:    left_dz     <= cfg_data[14:0];
          REG_RIGHT_DZ:   right_dz    <= cfg_data[14:0];
          REG_TRIG_LEVEL: trig_level  <= cfg_data[7:0];
          REG_RETRY:      retry_ticks <= cfg_data[15:0];
          default: ;
        endcase
      end

      // drop the result once transferred unless a new one loads
      if (result_valid && !result_stall && !res_load) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (poll_valid) begin
            item  <= poll_item;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          lane  <= '0;
          step  <= '0;
          if (due && item.poll_status == ST_OK &&
              item.packet_number != seen_packet[pad_sel]) begin
            seen_packet[pad_sel] <= item.packet_number;
            if (!linked) begin
              is_linked[pad_sel] <= 1'b1;
              retry_due[pad_sel] <= '0;
              state              <= S_CONN;
            end else begin
              state <= S_SETUP;
            end
          end else if (due && item.poll_status == ST_NO_DEVICE) begin
            retry_due[pad_sel] <= retry_at;
            if (linked) begin
              is_linked[pad_sel] <= 1'b0;
              state              <= S_DISC;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_CONN, S_DISC: begin
          if (out_free) begin
            result_valid               <= 1'b1;
            result_item.event_kind     <= (state == S_CONN) ? EVT_CONNECT : EVT_DISCONNECT;
            result_item.pad_out        <= item.pad_index;
            result_item.buttons_out    <= '0;
            result_item.left_x_out     <= '0;
            result_item.left_y_out     <= '0;
            result_item.right_x_out    <= '0;
            result_item.right_y_out    <= '0;
            result_item.left_trig_out  <= '0;
            result_item.right_trig_out <= '0;
            result_item.last_of_run    <= (state == S_DISC);
            state                      <= (state == S_CONN) ? S_SETUP : S_IDLE;
          end
        end
        S_SETUP: begin
          rem       <= op_h;
          low       <= op_den;
          dvs       <= op_d;
          quo       <= '0;
          lane_zero <= op_zero;
          lane_sat  <= op_h >= op_d;
          lane_neg  <= s_neg;
          lane_trig <= op_trig;
          step      <= '0;
          state     <= S_STEP;
        end
        S_STEP: begin
          rem  <= rem_next;
          low  <= low_next;
          quo  <= quo_next;
          step <= STEP_W'(step + 1'b1);
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            res[lane] <= finish(quo_next, lane_zero, lane_sat, lane_neg, lane_trig);
            if (lane == LANE_RT) begin
              state <= S_SEND;
            end else begin
              lane  <= LANE_W'(lane + 1'b1);
              state <= S_SETUP;
            end
          end
        end
        S_SEND: begin
          if (out_free) begin
            result_valid                <= 1'b1;
            result_item.event_kind      <= EVT_STATE;
            result_item.pad_out         <= item.pad_index;
            result_item.buttons_out     <= item.button_bits;
            result_item.left_x_out      <= res[LANE_LX];
            result_item.left_y_out      <= res[LANE_LY];
            result_item.right_x_out     <= res[LANE_RX];
            result_item.right_y_out     <= res[LANE_RY];
            result_item.left_trig_out   <= res[LANE_LT];
            result_item.right_trig_out  <= res[LANE_RT];
            result_item.last_of_run     <= 1'b1;
            state                       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/gpdc_checker.sv
// ----------------------------------------------------------------------------
// Gamepad poll conditioner checker
// Port-level assertions on result framing and input flow, bound to the top.
// ----------------------------------------------------------------------------
`include "gamepad_poll_deadzone_conditioner_macros.svh"

module gpdc_checker
  import gpdc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         poll_valid,
  input logic         poll_stall,
  input logic         result_valid,
  input logic         result_stall,
  input result_item_t result_item
);

  // hold a stalled result
  `GPDC_ASSERT_NXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result_item), "stalled result changed")

  // events carry no pad state
  `GPDC_ASSERT_IMP(a_event_clear, clk, rst, result_valid && result_item.event_kind != EVT_STATE, result_item.buttons_out == '0 && result_item.left_x_out == '0 && result_item.left_y_out == '0 && result_item.right_x_out == '0 && result_item.right_y_out == '0 && result_item.left_trig_out == '0 && result_item.right_trig_out == '0, "event result carries payload")

  // only a connect event leaves last_of_run clear
  `GPDC_ASSERT_IMP(a_last_flag, clk, rst, result_valid, result_item.last_of_run == (result_item.event_kind != EVT_CONNECT), "last_of_run inconsistent with kind")

  // the block works on one poll at a time
  `GPDC_ASSERT_NXT(a_busy_after_transfer, clk, rst, poll_valid && !poll_stall, poll_stall, "poll taken while busy")

endmodule

bind gamepad_poll_deadzone_conditioner gpdc_checker u_gpdc_checker (
  .clk          (clk),
  .rst          (rst),
  .poll_valid   (poll_valid),
  .poll_stall   (poll_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);

### verif/gpdc_result_checker.sv
// ----------------------------------------------------------------------------
// Gamepad poll conditioner result checker
// Watches the poll, result and register ports, keeps its own copy of the pad
// state and registers, predicts the results of every poll and compares each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gpdc_result_checker
  import gpdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  poll_valid,
  input  logic                  poll_stall,
  input  poll_item_t            poll_item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_item_t          result_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_total,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [14:0] left_dz;
  logic [14:0] right_dz;
  logic [7:0]  trig_level;
  logic [15:0] retry_ticks;

  logic [63:0] pad_retry_at [PAD_COUNT_DEF];
  logic [31:0] pad_last_pkt [PAD_COUNT_DEF];
  bit          pad_linked   [PAD_COUNT_DEF];

  result_item_t pending_results [$];
  int mismatches = 0;

  // Axial dead zone removal, rescale to Q1.15 with halves away from zero.
  function automatic logic [15:0] scale_stick(input logic signed [15:0] raw,
                                              input logic [14:0] dz);
    int     mag;
    int     dzi;
    longint den;
    longint q;
    dzi = int'(dz);
    mag = (raw < 0) ? -int'(raw) : int'(raw);
    if (mag <= dzi) return 16'd0;
    den = 32767 - dzi;
    if (den == 0) q = 32768;
    else q = (longint'(mag - dzi) * 65536 + den) / (2 * den);
    if (raw < 0) begin
      if (q > 32768) q = 32768;
      return 16'(65536 - q);
    end
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  // Threshold removal, rescale to Q0.16 with halves up.
  function automatic logic [15:0] scale_trigger(input logic [7:0] v, input logic [7:0] t);
    int     vi;
    int     ti;
    longint den;
    longint q;
    vi = int'(v);
    ti = int'(t);
    if (vi < ti) return 16'd0;
    den = 255 - ti;
    if (den == 0) return 16'd0;
    q = (longint'(vi - ti) * 131072 + den) / (2 * den);
    if (q > 65535) q = 65535;
    return 16'(q);
  endfunction

  function automatic void condition_poll(input poll_item_t p);
    int           pad;
    result_item_t r;
    pad = int'(p.pad_index);
    // drop polls that arrive before the retry time
    if (pad_retry_at[pad] != 64'd0 && p.now_tick < pad_retry_at[pad]) return;
    case (p.poll_status)
      ST_OK: begin
        if (p.packet_number == pad_last_pkt[pad]) return;
        if (!pad_linked[pad]) begin
          pad_linked[pad] = 1'b1;
          pad_retry_at[pad] = 64'd0;
          r = '0;
          r.event_kind = EVT_CONNECT;
          r.pad_out = p.pad_index;
          pending_results.push_back(r);
        end
        pad_last_pkt[pad] = p.packet_number;
        r = '0;
        r.event_kind = EVT_STATE;
        r.pad_out = p.pad_index;
        r.buttons_out = p.button_bits;
        r.left_x_out = scale_stick(p.left_x_raw, left_dz);
        r.left_y_out = scale_stick(p.left_y_raw, left_dz);
        r.right_x_out = scale_stick(p.right_x_raw, right_dz);
        r.right_y_out = scale_stick(p.right_y_raw, right_dz);
        r.left_trig_out = scale_trigger(p.left_trig_raw, trig_level);
        r.right_trig_out = scale_trigger(p.right_trig_raw, trig_level);
        r.last_of_run = 1'b1;
        pending_results.push_back(r);
      end
      ST_NO_DEVICE: begin
        if (pad_linked[pad]) begin
          pad_linked[pad] = 1'b0;
          r = '0;
          r.event_kind = EVT_DISCONNECT;
          r.pad_out = p.pad_index;
          r.last_of_run = 1'b1;
          pending_results.push_back(r);
        end
        // wraps modulo 2^64; a wrap to zero means poll now
        pad_retry_at[pad] = p.now_tick + {48'd0, retry_ticks};
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_item_t want;
    if (rst) begin
      left_dz = LEFT_DZ_RST;
      right_dz = RIGHT_DZ_RST;
      trig_level = TRIG_LEVEL_RST;
      retry_ticks = RETRY_RST;
      for (int i = 0; i < PAD_COUNT_DEF; i++) begin
        pad_retry_at[i] = 64'd0;
        pad_last_pkt[i] = 32'd0;
        pad_linked[i] = 1'b0;
      end
      pending_results.delete();
    end else begin
      // compare first: a result at this edge never comes from a poll at this edge
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, result_item);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("event_kind", want.event_kind, result_item.event_kind);
          check_field("pad_out", want.pad_out, result_item.pad_out);
          check_field("buttons_out", want.buttons_out, result_item.buttons_out);
          check_field("left_x_out", want.left_x_out, result_item.left_x_out);
          check_field("left_y_out", want.left_y_out, result_item.left_y_out);
          check_field("right_x_out", want.right_x_out, result_item.right_x_out);
          check_field("right_y_out", want.right_y_out, result_item.right_y_out);
          check_field("left_trig_out", want.left_trig_out, result_item.left_trig_out);
          check_field("right_trig_out", want.right_trig_out, result_item.right_trig_out);
          check_field("last_of_run", want.last_of_run, result_item.last_of_run);
        end
      end
      if (poll_valid && !poll_stall) condition_poll(poll_item);
      if (cfg_write) begin
        case (cfg_index)
          REG_LEFT_DZ:    left_dz = cfg_data[14:0];
          REG_RIGHT_DZ:   right_dz = cfg_data[14:0];
          REG_TRIG_LEVEL: trig_level = cfg_data[7:0];
          REG_RETRY:      retry_ticks = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_results.size();
    fail_total <= mismatches;
  end

endmodule

### verif/tb_gamepad_poll_deadzone_conditioner.sv
// ----------------------------------------------------------------------------
// Gamepad poll dead zone conditioner testbench
// Drives directed polls over the stick and trigger edges, retry gating and
// tick wrap, then random poll sequences under several register settings and
// idle/stall mixes. The result checker predicts and compares every transfer.
// ----------------------------------------------------------------------------
module tb_gamepad_poll_deadzone_conditioner
  import gpdc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ST_OTHER_ERR = 2'd2;
  localparam logic [1:0]  ST_SPARE_ERR = 2'd3;
  localparam logic [63:0] TICK_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          HOLD_CYCLES  = 40;
  localparam int          PHASE_POLLS  = 205;
  localparam int          CYCLE_LIMIT  = 2_000_000;

  logic                  clk;
  logic                  rst;
  logic                  poll_valid;
  logic                  poll_stall;
  poll_item_t            poll_item;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_item_t          result_item;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_total;
  int outstanding;

  int send_idle = 0;
  int recv_stall = 0;
  int cycle_count = 0;

  logic [14:0] left_dz_set;
  logic [14:0] right_dz_set;
  logic [7:0]  trig_set;
  logic [63:0] tick_base;
  logic [31:0] sent_pkt [4];

  gamepad_poll_deadzone_conditioner #(
    .PAD_COUNT(PAD_COUNT_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .poll_valid(poll_valid),
    .poll_stall(poll_stall),
    .poll_item(poll_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item(result_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  gpdc_result_checker checker_i (
    .clk(clk),
    .rst(rst),
    .poll_valid(poll_valid),
    .poll_stall(poll_stall),
    .poll_item(poll_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item(result_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_total(fail_total),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    result_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("gamepad_poll_deadzone_conditioner regression: fail");
      $finish;
    end
  end

  // Write all four registers back to back; unused data bits carry noise.
  task automatic apply_config(input logic [14:0] ldz, input logic [14:0] rdz,
                              input logic [7:0] lvl, input logic [15:0] retry);
    left_dz_set = ldz;
    right_dz_set = rdz;
    trig_set = lvl;
    cfg_write <= 1'b1;
    cfg_index <= REG_LEFT_DZ;
    cfg_data <= {1'($urandom), ldz};
    @(posedge clk);
    cfg_index <= REG_RIGHT_DZ;
    cfg_data <= {1'($urandom), rdz};
    @(posedge clk);
    cfg_index <= REG_TRIG_LEVEL;
    cfg_data <= {8'($urandom), lvl};
    @(posedge clk);
    cfg_index <= REG_RETRY;
    cfg_data <= retry;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_poll(input poll_item_t p);
    while ($urandom_range(99) < send_idle) begin
      poll_valid <= 1'b0;
      @(posedge clk);
    end
    poll_valid <= 1'b1;
    poll_item <= p;
    @(posedge clk);
    while (poll_stall) @(posedge clk);
  endtask

  // Hold off until every predicted result has arrived, then let the block settle.
  task automatic wait_drained();
    poll_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  function automatic poll_item_t make_poll(input logic [1:0] pad, input logic [63:0] tick,
                                           input logic [1:0] status, input logic [31:0] pkt,
                                           input logic [15:0] btn,
                                           input logic [15:0] lx, input logic [15:0] ly,
                                           input logic [15:0] rx, input logic [15:0] ry,
                                           input logic [7:0] lt, input logic [7:0] rt);
    poll_item_t p;
    p.pad_index = pad;
    p.now_tick = tick;
    p.poll_status = status;
    p.packet_number = pkt;
    p.button_bits = btn;
    p.left_x_raw = lx;
    p.left_y_raw = ly;
    p.right_x_raw = rx;
    p.right_y_raw = ry;
    p.left_trig_raw = lt;
    p.right_trig_raw = rt;
    return p;
  endfunction

  // Bias samples toward the dead zone edge and full scale.
  function automatic logic [15:0] pick_axis(input logic [14:0] dz);
    int m;
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return 16'($urandom);
    if (pick < 7) begin
      m = int'(dz) + int'($urandom_range(4)) - 2;
      if (m < 0) m = 0;
      if (m > 32767) m = 32767;
      return ($urandom_range(1) != 0) ? 16'(-m) : 16'(m);
    end
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h8001;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [7:0] pick_trigger(input logic [7:0] lvl);
    int m;
    if ($urandom_range(1) != 0) return 8'($urandom);
    m = int'(lvl) + int'($urandom_range(2)) - 1;
    if (m < 0) m = 0;
    if (m > 255) m = 255;
    return 8'(m);
  endfunction

  function automatic poll_item_t gen_poll();
    poll_item_t p;
    int         pick;
    int         pad;
    pad = $urandom_range(3);
    p.pad_index = 2'(pad);
    pick = $urandom_range(99);
    // an all-ones tick is always due and frees pads parked far ahead
    if (pick < 3) p.now_tick = TICK_MAX;
    else if (pick < 7) p.now_tick = {$urandom, $urandom};
    else if (pick < 12) p.now_tick = tick_base - 64'($urandom_range(200));
    else begin
      tick_base = tick_base + 64'($urandom_range(400));
      p.now_tick = tick_base;
    end
    pick = $urandom_range(99);
    if (pick < 74) p.poll_status = ST_OK;
    else if (pick < 88) p.poll_status = ST_NO_DEVICE;
    else if (pick < 94) p.poll_status = ST_OTHER_ERR;
    else p.poll_status = ST_SPARE_ERR;
    pick = $urandom_range(99);
    if (pick < 15) p.packet_number = sent_pkt[pad];
    else if (pick < 25) p.packet_number = $urandom;
    else p.packet_number = sent_pkt[pad] + 32'($urandom_range(1, 4));
    sent_pkt[pad] = p.packet_number;
    p.button_bits = 16'($urandom);
    p.left_x_raw = pick_axis(left_dz_set);
    p.left_y_raw = pick_axis(left_dz_set);
    p.right_x_raw = pick_axis(right_dz_set);
    p.right_y_raw = pick_axis(right_dz_set);
    p.left_trig_raw = pick_trigger(trig_set);
    p.right_trig_raw = pick_trigger(trig_set);
    return p;
  endfunction

  task automatic run_phase(input int target, input int idle_pct, input int stall_pct);
    int sent;
    bit held;
    send_idle = idle_pct;
    recv_stall = stall_pct;
    sent = 0;
    held = 1'b0;
    while (sent < target) begin
      send_poll(gen_poll());
      sent++;
      // pause the sender once mid-phase until the pipe is empty
      if (!held && sent >= target / 2) begin
        wait_drained();
        held = 1'b1;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    poll_valid <= 1'b0;
    poll_item <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_LEFT_DZ;
    cfg_data <= '0;
    tick_base = 64'd20000;
    foreach (sent_pkt[i]) sent_pkt[i] = 32'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    apply_config(LEFT_DZ_RST, RIGHT_DZ_RST, TRIG_LEVEL_RST, RETRY_RST);
    // packet zero matches the cleared last packet
    send_poll(make_poll(2'd0, 64'd10, ST_OK, 32'd0, 16'h1234,
                        16'h0100, 16'h0100, 16'h0100, 16'h0100, 8'd100, 8'd100));
    // full scale, samples exactly at the dead zone and the threshold
    send_poll(make_poll(2'd0, 64'd20, ST_OK, 32'd1, 16'h0000,
                        16'h7FFF, 16'h8000, 16'd8689, -16'sd8689, 8'd255, 8'd30));
    send_poll(make_poll(2'd0, 64'd30, ST_OK, 32'd1, 16'h5555,
                        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd255, 8'd255));
    send_poll(make_poll(2'd0, 64'd40, ST_OTHER_ERR, 32'd5, 16'hAAAA,
                        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd255, 8'd255));
    send_poll(make_poll(2'd0, 64'd50, ST_OK, 32'd2, 16'hFFFF,
                        16'd7850, -16'sd7850, 16'd8690, 16'h0000, 8'd29, 8'd0));
    send_poll(make_poll(2'd0, 64'd1000, ST_NO_DEVICE, 32'd2, 16'h0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0));
    // one tick short of the retry time, then exactly on it
    send_poll(make_poll(2'd0, 64'd5999, ST_OK, 32'd3, 16'h0F0F,
                        16'h4000, 16'hC000, 16'h4000, 16'hC000, 8'd128, 8'd128));
    send_poll(make_poll(2'd0, 64'd6000, ST_OK, 32'd3, 16'h0F0F,
                        16'h4000, 16'hC000, 16'h4000, 16'hC000, 8'd128, 8'd128));
    // retry time wraps to exactly zero
    send_poll(make_poll(2'd1, TICK_MAX - 64'd4999, ST_NO_DEVICE, 32'd0, 16'h0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0));
    send_poll(make_poll(2'd1, 64'd0, ST_OK, 32'd7, 16'h8001,
                        16'h8001, 16'h7FFE, 16'h0001, 16'hFFFF, 8'd31, 8'd254));
    // retry time wraps past zero to a small value
    send_poll(make_poll(2'd2, TICK_MAX - 64'd10, ST_NO_DEVICE, 32'd0, 16'h0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0));
    send_poll(make_poll(2'd2, 64'd100, ST_OK, 32'd1, 16'h00FF,
                        16'h2000, 16'h2000, 16'h2000, 16'h2000, 8'd60, 8'd60));
    send_poll(make_poll(2'd2, 64'd4989, ST_OK, 32'd1, 16'h00FF,
                        16'h2000, 16'hE000, 16'h2000, 16'hE000, 8'd60, 8'd60));
    send_poll(make_poll(2'd3, TICK_MAX, ST_OK, 32'hFFFF_FFFF, 16'hFFFF,
                        16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE, 8'd31, 8'd254));
    send_poll(make_poll(2'd3, TICK_MAX, ST_SPARE_ERR, 32'd9, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255));
    wait_drained();

    // full-scale left dead zone, zero right dead zone, trigger level 255, no retry wait
    apply_config(15'h7FFF, 15'd0, 8'hFF, 16'd0);
    send_poll(make_poll(2'd3, 64'd5, ST_OK, 32'd9, 16'h3C3C,
                        16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 8'd255, 8'd0));
    send_poll(make_poll(2'd3, 64'd6, ST_NO_DEVICE, 32'd9, 16'h0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0));
    send_poll(make_poll(2'd3, 64'd6, ST_OK, 32'd10, 16'hC3C3,
                        16'h8001, 16'h8000, 16'h8000, 16'h7FFF, 8'd254, 8'd128));
    wait_drained();

    apply_config(15'd0, 15'd32766, 8'd0, 16'hFFFF);
    send_poll(make_poll(2'd0, 64'd7000, ST_OK, 32'd4, 16'h6666,
                        16'h8000, 16'h7FFF, 16'h7FFF, 16'h8001, 8'd0, 8'd255));
    send_poll(make_poll(2'd0, 64'd7001, ST_OK, 32'd5, 16'h9999,
                        16'h8001, 16'h0001, 16'd32766, 16'h8000, 8'd1, 8'd128));
    wait_drained();

    apply_config(LEFT_DZ_RST, RIGHT_DZ_RST, TRIG_LEVEL_RST, RETRY_RST);
    run_phase(PHASE_POLLS, 0, 0);
    apply_config(15'($urandom_range(32766)), 15'($urandom_range(32766)),
                 8'($urandom_range(254)), 16'($urandom_range(1, 3000)));
    run_phase(PHASE_POLLS, 54, 0);
    apply_config(15'd0, 15'd0, 8'd0, 16'd1);
    run_phase(PHASE_POLLS, 0, 54);
    apply_config(15'h7FFF, 15'd32766, 8'hFF, 16'd0);
    run_phase(PHASE_POLLS, 25, 25);
    apply_config(15'($urandom_range(32766)), 15'($urandom_range(32766)),
                 8'($urandom_range(254)), 16'($urandom_range(1, 8000)));
    run_phase(PHASE_POLLS, 0, 0);
    apply_config(15'd32766, 15'd0, 8'd254, 16'hFFFF);
    run_phase(PHASE_POLLS, 54, 0);
    apply_config(15'($urandom_range(32766)), 15'($urandom_range(32766)),
                 8'($urandom_range(254)), 16'($urandom_range(1, 3000)));
    run_phase(PHASE_POLLS, 0, 54);
    apply_config(15'($urandom_range(32766)), 15'($urandom_range(32766)),
                 8'($urandom_range(254)), 16'($urandom_range(1, 3000)));
    run_phase(PHASE_POLLS, 25, 25);

    if (fail_total == 0 && outstanding == 0) begin
      $display("gamepad_poll_deadzone_conditioner regression: pass");
    end else begin
      $display("gamepad_poll_deadzone_conditioner regression: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/gpdc_pkg.sv
hw/rtl/gamepad_poll_deadzone_conditioner.sv
hw/rtl/gpdc_checker.sv
verif/gpdc_result_checker.sv
verif/tb_gamepad_poll_deadzone_conditioner.sv
